[sv/fxalu_pkg.sv]
// Shared constants, types and helper functions for the Q24.8 fixed-point ALU.
package fxalu_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 8;
   localparam int NUM_W     = DATA_W + FRAC_BITS;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int OP_W      = 4;

   localparam logic [OP_W-1:0] OP_ADD      = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB      = 4'd1;
   localparam logic [OP_W-1:0] OP_MUL      = 4'd2;
   localparam logic [OP_W-1:0] OP_DIV      = 4'd3;
   localparam logic [OP_W-1:0] OP_MIN      = 4'd4;
   localparam logic [OP_W-1:0] OP_MAX      = 4'd5;
   localparam logic [OP_W-1:0] OP_INC      = 4'd6;
   localparam logic [OP_W-1:0] OP_DEC      = 4'd7;
   localparam logic [OP_W-1:0] OP_TO_INT   = 4'd8;
   localparam logic [OP_W-1:0] OP_FROM_INT = 4'd9;

   localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [PROD_W-1:0] HALF  = PROD_W'(1) << (FRAC_BITS - 1);

   // control and early results that ride along the pipeline
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] simple_res;
      logic              simple_ovf;
      logic              less;
      logic              equal;
      logic              greater;
      logic              neg;
      logic              dz;
      logic [PROD_W-1:0] prod;
   } side_type;

   typedef struct packed {
      logic [DATA_W-1:0] result_raw;
      logic              less;
      logic              equal;
      logic              greater;
      logic              overflow;
      logic              divide_by_zero;
   } rsp_type;

   // saturate a 33-bit signed sum: returns {overflow, value}
   function automatic logic [DATA_W:0] sat_sum(input logic [DATA_W:0] v);
      logic [DATA_W:0] r;
      if (v[DATA_W] != v[DATA_W-1]) begin
         r = {1'b1, (v[DATA_W] ? Q_MIN : Q_MAX)};
      end else begin
         r = {1'b0, v[DATA_W-1:0]};
      end
      return r;
   endfunction

   // apply sign to a magnitude and saturate: returns {overflow, value}
   function automatic logic [DATA_W:0] sat_mag(input logic [PROD_W-1:0] mag, input logic neg);
      logic [DATA_W:0] r;
      if (neg) begin
         if (mag > PROD_W'(Q_MIN)) begin
            r = {1'b1, Q_MIN};
         end else begin
            r = {1'b0, -mag[DATA_W-1:0]};
         end
      end else begin
         if (mag > PROD_W'(Q_MAX)) begin
            r = {1'b1, Q_MAX};
         end else begin
            r = {1'b0, mag[DATA_W-1:0]};
         end
      end
      return r;
   endfunction

endpackage

[sv/fxalu_ifs.sv]
// Request and response channel interfaces.
interface fxalu_req_if;
   logic                                valid;
   logic                                ready;
   logic [fxalu_pkg::OP_W-1:0]          operation;
   logic signed [fxalu_pkg::DATA_W-1:0] operand_a;
   logic signed [fxalu_pkg::DATA_W-1:0] operand_b;
   modport source (output valid, operation, operand_a, operand_b, input ready);
   modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface fxalu_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [fxalu_pkg::DATA_W-1:0] result_raw;
   logic                                less;
   logic                                equal;
   logic                                greater;
   logic                                overflow;
   logic                                divide_by_zero;
   modport source (output valid, result_raw, less, equal, greater, overflow,
                   divide_by_zero, input ready);
   modport sink   (input valid, result_raw, less, equal, greater, overflow,
                   divide_by_zero, output ready);
endinterface

[sv/fxalu_front.sv]
// Front stages: decode, simple results, magnitudes, then the 32x32 multiply.
module fxalu_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [fxalu_pkg::OP_W-1:0]          operation,
   input  logic signed [fxalu_pkg::DATA_W-1:0] operand_a,
   input  logic signed [fxalu_pkg::DATA_W-1:0] operand_b,
   output logic                                out_valid,
   output fxalu_pkg::side_type                 out_side,
   output logic [fxalu_pkg::NUM_W-1:0]         out_num,
   output logic [fxalu_pkg::DATA_W-1:0]        out_den
);
   localparam int DW = fxalu_pkg::DATA_W;
   localparam int FB = fxalu_pkg::FRAC_BITS;

   fxalu_pkg::side_type s1_side_in, s1_side_ff, s2_side_in, s2_side_ff;
   logic          s1_valid_ff, s2_valid_ff;
   logic [DW-1:0] mag_a_in, mag_b_in, mag_a_ff, mag_b_ff;
   logic [DW:0]   sum, diff, incv, decv, sat;
   logic [DW-1:0] trunc;
   logic [FB:0]   hi;

   always_comb begin
      mag_a_in = operand_a[DW-1] ? -operand_a : operand_a;
      mag_b_in = operand_b[DW-1] ? -operand_b : operand_b;
      sum   = {operand_a[DW-1], operand_a} + {operand_b[DW-1], operand_b};
      diff  = {operand_a[DW-1], operand_a} - {operand_b[DW-1], operand_b};
      incv  = {operand_a[DW-1], operand_a} + (DW+1)'(1);
      decv  = {operand_a[DW-1], operand_a} - (DW+1)'(1);
      trunc = mag_a_in >> FB;
      hi    = operand_a[DW-1 -: FB+1];
      sat   = '0;

      s1_side_in         = '0;
      s1_side_in.op      = operation;
      s1_side_in.less    = operand_a < operand_b;
      s1_side_in.equal   = operand_a == operand_b;
      s1_side_in.greater = operand_a > operand_b;
      s1_side_in.neg     = operand_a[DW-1] ^ operand_b[DW-1];
      s1_side_in.dz      = (operation == fxalu_pkg::OP_DIV) && (operand_b == '0);

      case (operation)
         fxalu_pkg::OP_ADD: sat = fxalu_pkg::sat_sum(sum);
         fxalu_pkg::OP_SUB: sat = fxalu_pkg::sat_sum(diff);
         fxalu_pkg::OP_INC: sat = fxalu_pkg::sat_sum(incv);
         fxalu_pkg::OP_DEC: sat = fxalu_pkg::sat_sum(decv);
         fxalu_pkg::OP_MIN: sat = {1'b0, (operand_a > operand_b) ? operand_b : operand_a};
         fxalu_pkg::OP_MAX: sat = {1'b0, (operand_a > operand_b) ? operand_a : operand_b};
         fxalu_pkg::OP_TO_INT: sat = {1'b0, (operand_a[DW-1] ? -trunc : trunc)};
         fxalu_pkg::OP_FROM_INT: begin
            if (!((&hi) || !(|hi))) begin
               sat = {1'b1, (operand_a[DW-1] ? fxalu_pkg::Q_MIN : fxalu_pkg::Q_MAX)};
            end else begin
               sat = {1'b0, operand_a[DW-FB-1:0], {FB{1'b0}}};
            end
         end
         default: sat = '0;
      endcase
      s1_side_in.simple_ovf = sat[DW];
      s1_side_in.simple_res = sat[DW-1:0];
   end

   always_comb begin
      s2_side_in      = s1_side_ff;
      s2_side_in.prod = fxalu_pkg::PROD_W'(mag_a_ff) * fxalu_pkg::PROD_W'(mag_b_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_side_ff <= s1_side_in;
         mag_a_ff   <= mag_a_in;
         mag_b_ff   <= mag_b_in;
         s2_side_ff <= s2_side_in;
         out_num    <= {mag_a_ff, {FB{1'b0}}};
         out_den    <= mag_b_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_side  = s2_side_ff;
endmodule

[sv/fxalu_divider.sv]
// Pipelined restoring divider, one quotient bit per stage.
module fxalu_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  fxalu_pkg::side_type          in_side,
   input  logic [fxalu_pkg::NUM_W-1:0]  in_num,
   input  logic [fxalu_pkg::DATA_W-1:0] in_den,
   output logic                         out_valid,
   output fxalu_pkg::side_type          out_side,
   output logic [fxalu_pkg::NUM_W-1:0]  out_quo,
   output logic [fxalu_pkg::DATA_W-1:0] out_rem,
   output logic [fxalu_pkg::DATA_W-1:0] out_den
);
   localparam int DW = fxalu_pkg::DATA_W;
   localparam int NW = fxalu_pkg::NUM_W;

   logic                valid_ff [NW];
   fxalu_pkg::side_type side_ff  [NW];
   logic [NW-1:0]       num_ff   [NW];
   logic [NW-1:0]       quo_ff   [NW];
   logic [NW-1:0]       quo_in   [NW];
   logic [DW-1:0]       den_ff   [NW];
   logic [DW-1:0]       rem_ff   [NW];
   logic [DW-1:0]       rem_in   [NW];

   always_comb begin
      logic [DW:0]   trial;
      logic [DW-1:0] rem_src, den_src;
      logic [NW-1:0] num_src, quo_src;
      logic          take;
      for (int k = 0; k < NW; k++) begin
         rem_src = (k == 0) ? '0 : rem_ff[(k == 0) ? 0 : k-1];
         quo_src = (k == 0) ? '0 : quo_ff[(k == 0) ? 0 : k-1];
         num_src = (k == 0) ? in_num : num_ff[(k == 0) ? 0 : k-1];
         den_src = (k == 0) ? in_den : den_ff[(k == 0) ? 0 : k-1];
         trial   = {rem_src, num_src[NW-1-k]};
         take    = trial >= {1'b0, den_src};
         rem_in[k] = take ? DW'(trial - {1'b0, den_src}) : trial[DW-1:0];
         quo_in[k] = {quo_src[NW-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NW; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < NW; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         num_ff[0]  <= in_num;
         den_ff[0]  <= in_den;
         for (int k = 1; k < NW; k++) begin
            side_ff[k] <= side_ff[k-1];
            num_ff[k]  <= num_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
         end
         for (int k = 0; k < NW; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign out_side  = side_ff[NW-1];
   assign out_quo   = quo_ff[NW-1];
   assign out_rem   = rem_ff[NW-1];
   assign out_den   = den_ff[NW-1];
endmodule

[sv/fxalu_post.sv]
// Final stage: rounding, saturation, result select and the output register.
module fxalu_post (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  fxalu_pkg::side_type          in_side,
   input  logic [fxalu_pkg::NUM_W-1:0]  in_quo,
   input  logic [fxalu_pkg::DATA_W-1:0] in_rem,
   input  logic [fxalu_pkg::DATA_W-1:0] in_den,
   output logic                         out_valid,
   output fxalu_pkg::rsp_type           out_rsp
);
   localparam int DW = fxalu_pkg::DATA_W;
   localparam int PW = fxalu_pkg::PROD_W;

   fxalu_pkg::rsp_type rsp_in;
   logic               valid_ff;
   logic [PW-1:0]      mul_q, div_q;
   logic [DW:0]        mul_s, div_s;
   logic               rnd;

   always_comb begin
      mul_q = (in_side.prod + fxalu_pkg::HALF) >> fxalu_pkg::FRAC_BITS;
      rnd   = {in_rem, 1'b0} >= {1'b0, in_den};
      div_q = PW'(in_quo) + PW'(rnd);
      mul_s = fxalu_pkg::sat_mag(mul_q, in_side.neg);
      div_s = fxalu_pkg::sat_mag(div_q, in_side.neg);

      rsp_in                = '0;
      rsp_in.less           = in_side.less;
      rsp_in.equal          = in_side.equal;
      rsp_in.greater        = in_side.greater;
      rsp_in.divide_by_zero = in_side.dz;
      case (in_side.op)
         fxalu_pkg::OP_MUL: begin
            rsp_in.result_raw = mul_s[DW-1:0];
            rsp_in.overflow   = mul_s[DW];
         end
         fxalu_pkg::OP_DIV: begin
            rsp_in.result_raw = in_side.dz ? '0 : div_s[DW-1:0];
            rsp_in.overflow   = !in_side.dz && div_s[DW];
         end
         default: begin
            rsp_in.result_raw = in_side.simple_res;
            rsp_in.overflow   = in_side.simple_ovf;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_rsp <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
endmodule

[sv/fixed_point_q24_8_alu_unit.sv]
// Top level of the signed Q24.8 fixed-point ALU pipeline.
// Stages: 2 front stages, 40 restoring-divider stages and 1 output stage lie
//   between request accept and response valid.
// Throughput: one request per cycle unless stalled; the 40-stage divider sets depth.
// Stall: the whole pipeline freezes while the output holds an untaken response.
// Reset: synchronous, active high; clears all stage valid bits, data is not reset.
module fixed_point_q24_8_alu_unit (
   input  logic        clock,
   input  logic        reset,
   fxalu_req_if.sink   req_chan,
   fxalu_rsp_if.source rsp_chan
);
   localparam int NW = fxalu_pkg::NUM_W;
   localparam int DW = fxalu_pkg::DATA_W;

   logic                en;
   logic                fr_valid, dv_valid, post_valid;
   fxalu_pkg::side_type fr_side, dv_side;
   logic [NW-1:0]       fr_num, dv_quo;
   logic [DW-1:0]       fr_den, dv_rem, dv_den;
   fxalu_pkg::rsp_type  rsp;

   // advance everything unless a finished response sits unclaimed
   assign en             = !post_valid || rsp_chan.ready;
   assign req_chan.ready = en;

   fxalu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .operation (req_chan.operation),
      .operand_a (req_chan.operand_a),
      .operand_b (req_chan.operand_b),
      .out_valid (fr_valid),
      .out_side  (fr_side),
      .out_num   (fr_num),
      .out_den   (fr_den)
   );

   // |a|*256 / |b|; sideband travels with each quotient
   fxalu_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_side   (fr_side),
      .in_num    (fr_num),
      .in_den    (fr_den),
      .out_valid (dv_valid),
      .out_side  (dv_side),
      .out_quo   (dv_quo),
      .out_rem   (dv_rem),
      .out_den   (dv_den)
   );

   fxalu_post u_post (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dv_valid),
      .in_side   (dv_side),
      .in_quo    (dv_quo),
      .in_rem    (dv_rem),
      .in_den    (dv_den),
      .out_valid (post_valid),
      .out_rsp   (rsp)
   );

   assign rsp_chan.valid          = post_valid;
   assign rsp_chan.result_raw     = rsp.result_raw;
   assign rsp_chan.less           = rsp.less;
   assign rsp_chan.equal          = rsp.equal;
   assign rsp_chan.greater        = rsp.greater;
   assign rsp_chan.overflow       = rsp.overflow;
   assign rsp_chan.divide_by_zero = rsp.divide_by_zero;

   // exactly one compare flag per response
   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      post_valid |-> $onehot({rsp.less, rsp.equal, rsp.greater}))
      else $error("compare flags not one-hot");

   // divide by zero yields zero without overflow
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      post_valid && rsp.divide_by_zero |-> (rsp.result_raw == '0) && !rsp.overflow)
      else $error("divide by zero response malformed");

   // a stalled response must hold back new requests
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      post_valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request taken during output stall");

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !post_valid)
      else $error("response valid right after reset");
endmodule
